FILE: rtl/nci_pkg.sv
// shared types, constants and rule tables for the newton-cotes integrator
package nci_pkg;

  localparam int MAX_DIVISIONS_DEF = 256;
  localparam int MAX_DEGREE_DEF    = 9;

  localparam int BOUND_W = 24;
  localparam int OUT_W   = 64;
  localparam int DEG_W   = 4;
  localparam int PAN_W   = 9;
  localparam int TOT_W   = DEG_W + PAN_W;
  localparam int DEN_W   = 46;
  localparam int ACC_W   = 128;
  localparam int CNT_W   = 7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [0:0] CFG_DEGREE = 1'b0;
  localparam logic [0:0] CFG_PANELS = 1'b1;

  typedef struct packed {
    logic signed [BOUND_W-1:0] lower_bound;
    logic signed [BOUND_W-1:0] upper_bound;
  } nci_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] integral;
    logic [1:0]              status;
  } nci_out_t;

  typedef struct packed {
    logic             load;
    logic             setup;
    logic             sdiv_init;
    logic             sdiv_step;
    logic             node_start;
    logic             mul_start_h;
    logic             mul_start_w;
    logic             mul_start_f;
    logic             mul_step;
    logic             horner_fin;
    logic             wacc;
    logic             adv;
    logic             fdiv_step;
    logic             fround;
    logic             res_store;
    logic [1:0]       chunk;
    logic [1:0]       hstep;
    logic [DEG_W-1:0] node_idx;
  } nci_cmd_t;

  typedef struct packed {
    logic             a_ge_b;
    logic [DEG_W-1:0] deg;
    logic [PAN_W-1:0] pan;
  } nci_stat_t;

  localparam logic signed [15:0] WEIGHT_TAB [10][10] = '{
    '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd1, 16'sd4, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd1, 16'sd3, 16'sd3, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd7, 16'sd32, 16'sd12, 16'sd32, 16'sd7, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd19, 16'sd75, 16'sd50, 16'sd50, 16'sd75, 16'sd19, 16'sd0, 16'sd0, 16'sd0,
      16'sd0},
    '{16'sd41, 16'sd216, 16'sd27, 16'sd272, 16'sd27, 16'sd216, 16'sd41, 16'sd0, 16'sd0,
      16'sd0},
    '{16'sd751, 16'sd3577, 16'sd1323, 16'sd2989, 16'sd2989, 16'sd1323, 16'sd3577,
      16'sd751, 16'sd0, 16'sd0},
    '{16'sd989, 16'sd5888, -16'sd928, 16'sd10496, -16'sd4540, 16'sd10496, -16'sd928,
      16'sd5888, 16'sd989, 16'sd0},
    '{16'sd2857, 16'sd15741, 16'sd1080, 16'sd19344, 16'sd5778, 16'sd5778, 16'sd19344,
      16'sd1080, 16'sd15741, 16'sd2857}
  };

  localparam logic [3:0] MULT_NUM [10] = '{4'd1, 4'd1, 4'd1, 4'd3, 4'd2, 4'd5, 4'd1, 4'd7,
                                           4'd4, 4'd9};
  localparam logic [16:0] MULT_DEN [10] = '{17'd1, 17'd2, 17'd3, 17'd8, 17'd45, 17'd288,
                                            17'd140, 17'd17280, 17'd14175, 17'd89600};

endpackage

FILE: rtl/nci_ctrl.sv
// sequencer for node loop, horner steps, multiply chunks and final divide
module nci_ctrl
  import nci_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  nci_stat_t stat_i,
  output nci_cmd_t  cmd_o
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_SETUP  = 17'b00000000000000010,
    S_SINIT  = 17'b00000000000000100,
    S_SDIV   = 17'b00000000000001000,
    S_NODE   = 17'b00000000000010000,
    S_HLOAD  = 17'b00000000000100000,
    S_HMUL   = 17'b00000000001000000,
    S_HFIN   = 17'b00000000010000000,
    S_WLOAD  = 17'b00000000100000000,
    S_WMUL   = 17'b00000001000000000,
    S_WACC   = 17'b00000010000000000,
    S_FLOAD  = 17'b00000100000000000,
    S_FMUL   = 17'b00001000000000000,
    S_FDIV   = 17'b00010000000000000,
    S_FROUND = 17'b00100000000000000,
    S_DONE   = 17'b01000000000000000,
    S_SPARE  = 17'b10000000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEG_W-1:0] i_q, i_d;
  logic [PAN_W-1:0] j_q, j_d;
  logic [1:0]       h_q, h_d;
  logic             ov_q, ov_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    j_d     = j_q;
    h_d     = h_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    cmd_o.chunk    = cnt_q[1:0];
    cmd_o.hstep    = h_q;
    cmd_o.node_idx = i_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = stat_i.a_ge_b ? S_DONE : S_SINIT;
      end
      S_SINIT: begin
        cmd_o.sdiv_init = 1'b1;
        cnt_d   = '0;
        i_d     = '0;
        j_d     = '0;
        state_d = S_SDIV;
      end
      S_SDIV: begin
        cmd_o.sdiv_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(BOUND_W - 1)) state_d = S_NODE;
      end
      S_NODE: begin
        cmd_o.node_start = 1'b1;
        h_d     = '0;
        state_d = S_HLOAD;
      end
      S_HLOAD: begin
        cmd_o.mul_start_h = 1'b1;
        cnt_d   = '0;
        state_d = S_HMUL;
      end
      S_HMUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(1)) state_d = S_HFIN;
      end
      S_HFIN: begin
        cmd_o.horner_fin = 1'b1;
        if (h_q == 2'd3) begin
          state_d = S_WLOAD;
        end else begin
          h_d     = h_q + 1'b1;
          state_d = S_HLOAD;
        end
      end
      S_WLOAD: begin
        cmd_o.mul_start_w = 1'b1;
        cnt_d   = '0;
        state_d = S_WMUL;
      end
      S_WMUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(1)) state_d = S_WACC;
      end
      S_WACC: begin
        cmd_o.wacc = 1'b1;
        if (i_q == stat_i.deg) begin
          // panel end node is shared with the next panel start, offset holds
          i_d = '0;
          if (j_q == stat_i.pan - 1'b1) begin
            state_d = S_FLOAD;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_NODE;
          end
        end else begin
          cmd_o.adv = 1'b1;
          i_d       = i_q + 1'b1;
          state_d   = S_NODE;
        end
      end
      S_FLOAD: begin
        cmd_o.mul_start_f = 1'b1;
        cnt_d   = '0;
        state_d = S_FMUL;
      end
      S_FMUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(3)) begin
          cnt_d   = '0;
          state_d = S_FDIV;
        end
      end
      S_FDIV: begin
        cmd_o.fdiv_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ACC_W - 1)) state_d = S_FROUND;
      end
      S_FROUND: begin
        cmd_o.fround = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.res_store = 1'b1;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      h_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
      h_q     <= h_d;
      ov_q    <= ov_d;
    end
  end

  a_load_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_SETUP)
    else $error("accepted word did not start setup");

  a_panel_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WACC |-> (j_q < stat_i.pan) && (i_q <= stat_i.deg))
    else $error("node counters out of range");

  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FDIV && $past(state_q) != S_FDIV) |-> $past(state_q) == S_FMUL)
    else $error("final divide entered without product");

  a_store_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_store |=> ov_q && state_q == S_IDLE)
    else $error("result store did not raise out valid");

endmodule

FILE: rtl/nci_datapath.sv
// config registers, node offsets, shared 32x32 multiplier, accumulator and divider
module nci_datapath
  import nci_pkg::*;
#(
  parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF,
  parameter int MAX_DEGREE    = MAX_DEGREE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [PAN_W-1:0] cfg_wdata_i,
  input  nci_in_t          in_data_i,
  input  nci_cmd_t         cmd_i,
  output nci_stat_t        stat_o,
  output nci_out_t         out_data_o
);

  logic [DEG_W-1:0] cfg_deg_q;
  logic [PAN_W-1:0] cfg_pan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_deg_q <= DEG_W'(1);
      cfg_pan_q <= PAN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEGREE: cfg_deg_q <= cfg_wdata_i[DEG_W-1:0];
        CFG_PANELS: cfg_pan_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [DEG_W-1:0] deg_eff;
  logic [PAN_W-1:0] pan_eff;

  always_comb begin
    if (cfg_deg_q == '0)                     deg_eff = DEG_W'(1);
    else if (int'(cfg_deg_q) > MAX_DEGREE)   deg_eff = DEG_W'(MAX_DEGREE);
    else                                     deg_eff = cfg_deg_q;
    if (cfg_pan_q == '0)                     pan_eff = PAN_W'(1);
    else if (int'(cfg_pan_q) > MAX_DIVISIONS) pan_eff = PAN_W'(MAX_DIVISIONS);
    else                                     pan_eff = cfg_pan_q;
  end

  logic signed [BOUND_W-1:0] a_q;
  logic [BOUND_W-1:0]        span_q;
  logic                      agb_q;
  logic [DEG_W-1:0]          deg_q;
  logic [PAN_W-1:0]          pan_q;
  logic [TOT_W-1:0]          total_q;
  logic [31:0]               nspan_q;
  logic [DEN_W-1:0]          den_q;
  logic [BOUND_W-1:0]        sd_q;
  logic [TOT_W-1:0]          sr_q;
  logic [BOUND_W-1:0]        off_q;
  logic [TOT_W-1:0]          offr_q;
  logic signed [BOUND_W-1:0] x_q;
  logic signed [63:0]        acc_q;
  logic [ACC_W-1:0]          ma_q;
  logic [31:0]               mb_q;
  logic [ACC_W-1:0]          p_q;
  logic                      mneg_q;
  logic [ACC_W-1:0]          sum_q;
  logic                      sneg_q;
  logic [DEN_W-1:0]          rem_q;
  nci_out_t                  res_q;

  assign stat_o.a_ge_b = agb_q;
  assign stat_o.deg    = deg_q;
  assign stat_o.pan    = pan_q;
  assign out_data_o    = res_q;

  logic signed [BOUND_W:0] span_w;
  assign span_w = BOUND_W'(0) + ({in_data_i.upper_bound[BOUND_W-1], in_data_i.upper_bound}
                - {in_data_i.lower_bound[BOUND_W-1], in_data_i.lower_bound});

  // span / total, one quotient bit per step
  logic [TOT_W:0] sdt;
  logic           sdge;
  assign sdt  = {sr_q, sd_q[BOUND_W-1]};
  assign sdge = sdt >= {1'b0, total_q};

  // node offset stepping: quotient/remainder of span*k + total/2 over total
  logic [TOT_W:0] offr_t;
  logic           offr_ge;
  assign offr_t  = {1'b0, offr_q} + {1'b0, sr_q};
  assign offr_ge = offr_t >= {1'b0, total_q};

  logic signed [BOUND_W-1:0] x_node;
  assign x_node = a_q + $signed(off_q);

  logic [63:0] acc_mag;
  assign acc_mag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
  logic [BOUND_W-1:0] x_mag;
  assign x_mag = x_q[BOUND_W-1] ? BOUND_W'(-x_q) : BOUND_W'(x_q);

  logic signed [15:0] wgt;
  logic [15:0]        w_mag;
  assign wgt   = WEIGHT_TAB[deg_q][cmd_i.node_idx];
  assign w_mag = wgt[15] ? 16'(-wgt) : 16'(wgt);

  logic [63:0]      mprod;
  logic [ACC_W-1:0] mpart;
  assign mprod = {32'b0, ma_q[31:0]} * {32'b0, mb_q};
  assign mpart = {64'b0, mprod} << {cmd_i.chunk, 5'b0};

  logic [ACC_W-1:0]   p_rnd;
  logic [61:0]        h_r;
  logic signed [63:0] h_sgn;
  assign p_rnd = p_q + ACC_W'(16'h8000);
  assign h_r   = p_rnd[77:16];
  assign h_sgn = mneg_q ? -$signed({2'b0, h_r}) : $signed({2'b0, h_r});

  logic [ACC_W-1:0] sum_mag;
  assign sum_mag = sum_q[ACC_W-1] ? -sum_q : sum_q;

  logic [DEN_W:0] dvt;
  logic           dvge;
  assign dvt  = {rem_q, p_q[ACC_W-1]};
  assign dvge = dvt >= {1'b0, den_q};

  logic rnd_up;
  assign rnd_up = {1'b0, rem_q} >= ({1'b0, den_q} - {1'b0, rem_q});

  nci_out_t res_new;
  always_comb begin
    res_new = '{integral: '0, status: ST_OK};
    if (agb_q) begin
      res_new.status = ST_ORDER;
    end else if (!sneg_q) begin
      if (|p_q[ACC_W-1:OUT_W-1]) begin
        res_new.integral = {1'b0, {(OUT_W-1){1'b1}}};
        res_new.status   = ST_SAT;
      end else begin
        res_new.integral = p_q[OUT_W-1:0];
      end
    end else begin
      if ((|p_q[ACC_W-1:OUT_W]) || (p_q[OUT_W-1:0] > {1'b1, {(OUT_W-1){1'b0}}})) begin
        res_new.integral = {1'b1, {(OUT_W-1){1'b0}}};
        res_new.status   = ST_SAT;
      end else begin
        res_new.integral = -p_q[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= in_data_i.lower_bound;
      span_q <= span_w[BOUND_W-1:0];
      agb_q  <= in_data_i.lower_bound >= in_data_i.upper_bound;
      deg_q  <= deg_eff;
      pan_q  <= pan_eff;
    end
    if (cmd_i.setup) begin
      total_q <= TOT_W'(deg_q) * TOT_W'(pan_q);
      nspan_q <= 32'(MULT_NUM[deg_q]) * 32'(span_q);
    end
    if (cmd_i.sdiv_init) begin
      den_q  <= {30'(MULT_DEN[deg_q]) * 30'(total_q), 16'b0};
      sd_q   <= span_q;
      sr_q   <= '0;
      off_q  <= '0;
      offr_q <= total_q >> 1;
      sum_q  <= '0;
    end
    if (cmd_i.sdiv_step) begin
      sr_q <= sdge ? TOT_W'(sdt - {1'b0, total_q}) : sdt[TOT_W-1:0];
      sd_q <= {sd_q[BOUND_W-2:0], sdge};
    end
    if (cmd_i.adv) begin
      if (offr_ge) begin
        offr_q <= TOT_W'(offr_t - {1'b0, total_q});
        off_q  <= off_q + sd_q + 1'b1;
      end else begin
        offr_q <= offr_t[TOT_W-1:0];
        off_q  <= off_q + sd_q;
      end
    end
    if (cmd_i.node_start) begin
      x_q   <= x_node;
      acc_q <= 64'(x_node) + (64'sd2 <<< 16);
    end
    if (cmd_i.mul_start_h) begin
      ma_q   <= ACC_W'(acc_mag);
      mb_q   <= 32'(x_mag);
      mneg_q <= acc_q[63] != x_q[BOUND_W-1];
      p_q    <= '0;
    end
    if (cmd_i.mul_start_w) begin
      ma_q   <= ACC_W'(acc_mag);
      mb_q   <= 32'(w_mag);
      mneg_q <= acc_q[63] != wgt[15];
      p_q    <= '0;
    end
    if (cmd_i.mul_start_f) begin
      ma_q   <= sum_mag;
      mb_q   <= nspan_q;
      sneg_q <= sum_q[ACC_W-1];
      p_q    <= '0;
      rem_q  <= '0;
    end
    if (cmd_i.mul_step) begin
      p_q  <= p_q + mpart;
      ma_q <= ma_q >> 32;
    end
    if (cmd_i.horner_fin) begin
      acc_q <= h_sgn + (64'(cmd_i.hstep + 3'd3) <<< 16);
    end
    if (cmd_i.wacc) begin
      sum_q <= sum_q + (mneg_q ? -p_q : p_q);
    end
    if (cmd_i.fdiv_step) begin
      rem_q <= dvge ? DEN_W'(dvt - {1'b0, den_q}) : dvt[DEN_W-1:0];
      p_q   <= {p_q[ACC_W-2:0], dvge};
    end
    if (cmd_i.fround) begin
      p_q <= p_q + ACC_W'(rnd_up);
    end
    if (cmd_i.res_store) begin
      res_q <= res_new;
    end
  end

endmodule

FILE: rtl/newton_cotes_integrator_top.sv
// composite newton-cotes integrator of a fixed quintic, one item at a time
// each node takes a horner pass of four two-chunk multiplies on the one 32x32 multiplier
// then a two-chunk weight multiply; the 128-step bit-serial divide closes the item
// a >= b skips the node loop and divide and goes straight to the result store
// next word taken in the cycle after a store, even while the result waits
// reset: degree 1, panel count 1, controller idle, no result pending
module newton_cotes_integrator_top
  import nci_pkg::*;
#(
  parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF,
  parameter int MAX_DEGREE    = MAX_DEGREE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [PAN_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  nci_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nci_out_t         out_data_o
);

  nci_cmd_t  cmd;
  nci_stat_t stat;

  nci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nci_datapath #(
    .MAX_DIVISIONS(MAX_DIVISIONS),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

FILE: dv/tb_newton_cotes_integrator_top.sv
// self-checking testbench for the composite newton-cotes integrator top level
module tb_newton_cotes_integrator_top
  import nci_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [0:0]       cfg_idx_i;
  logic [PAN_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  nci_in_t          in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  nci_out_t         out_data_o;

  newton_cotes_integrator_top dut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  nci_in_t   bound_q[$];
  nci_out_t  integral_q[$];
  int unsigned rule_deg  = 1;
  int unsigned rule_pans = 1;
  int unsigned error_cnt = 0;
  int unsigned words_in  = 0;
  int unsigned words_out = 0;
  int unsigned hold_reqs = 0;
  bit          no_idle   = 1'b0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("error: %s got %0h want %0h (result %0d)", what, got, want, words_out);
    error_cnt++;
  endtask

  // round(a*b/2^16), halves away from zero
  function automatic longint qmul_q16(longint a, longint b);
    logic [127:0]    prod;
    longint unsigned ma, mb, r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    prod = 128'(ma) * 128'(mb) + 128'h8000;
    r = prod[79:16] & 64'h3FFF_FFFF_FFFF_FFFF;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint quintic(longint x);
    longint acc;
    acc = x + (longint'(2) << 16);
    acc = qmul_q16(acc, x) + (longint'(3) << 16);
    acc = qmul_q16(acc, x) + (longint'(4) << 16);
    acc = qmul_q16(acc, x) + (longint'(5) << 16);
    acc = qmul_q16(acc, x) + (longint'(6) << 16);
    return acc;
  endfunction

  function automatic nci_out_t integral_of(nci_in_t w);
    nci_out_t               res;
    longint                 a, b;
    longint unsigned        span, total, off, k, den;
    int unsigned            d, n;
    logic signed [127:0]    sum, fxw, ww;
    logic [127:0]           mag, q, rem, den_w;
    bit                     neg;
    a = w.lower_bound;
    b = w.upper_bound;
    if (a >= b) begin
      res.integral = '0;
      res.status   = ST_ORDER;
      return res;
    end
    d = (rule_deg == 0) ? 1 : ((rule_deg > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : rule_deg);
    n = (rule_pans == 0) ? 1 :
        ((rule_pans > MAX_DIVISIONS_DEF) ? MAX_DIVISIONS_DEF : rule_pans);
    span  = b - a;
    total = d * n;
    sum   = '0;
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i <= d; i++) begin
        k   = j * d + i;
        off = (span * k + total / 2) / total;
        fxw = quintic(a + longint'(off));
        ww  = WEIGHT_TAB[d][i];
        sum = sum + fxw * ww;
      end
    end
    neg   = sum[127];
    mag   = neg ? -sum : sum;
    mag   = mag * 128'(MULT_NUM[d]);
    mag   = mag * 128'(span);
    den   = (longint'(MULT_DEN[d]) * total) << 16;
    den_w = 128'(den);
    q     = mag / den_w;
    rem   = mag % den_w;
    if (rem >= den_w - rem) q = q + 1;
    if (!neg) begin
      if (q > 128'h7FFF_FFFF_FFFF_FFFF) begin
        res.integral = 64'h7FFF_FFFF_FFFF_FFFF;
        res.status   = ST_SAT;
      end else begin
        res.integral = q[63:0];
        res.status   = ST_OK;
      end
    end else begin
      if (q > 128'h8000_0000_0000_0000) begin
        res.integral = 64'h8000_0000_0000_0000;
        res.status   = ST_SAT;
      end else begin
        res.integral = -q[63:0];
        res.status   = ST_OK;
      end
    end
    return res;
  endfunction

  // driver: offers queued bounds, with random gap bursts
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_left   <= 0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i && in_ready_o) begin
        integral_q.push_back(integral_of(in_data_i));
        words_in++;
      end
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap_left   <= $urandom_range(0, 10);
        in_valid_i <= 1'b0;
      end else if (bound_q.size() > 0) begin
        in_data_i  <= bound_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: checks results, stalls at random and on request for a long stretch
  int unsigned stall_left;
  int unsigned holds_done;
  always @(posedge clk_i or negedge rst_ni) begin
    nci_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
      holds_done  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (integral_q.size() == 0) begin
          report_mismatch("unexpected word", out_data_o.integral, '0);
        end else begin
          want = integral_q.pop_front();
          if (out_data_o.integral !== want.integral)
            report_mismatch("integral", out_data_o.integral, want.integral);
          if (out_data_o.status !== want.status)
            report_mismatch("status", 64'(out_data_o.status), 64'(want.status));
        end
        words_out++;
      end
      if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (holds_done < hold_reqs) begin
        holds_done  <= holds_done + 1;
        stall_left  <= 3000;
        out_ready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        stall_left  <= $urandom_range(0, 10);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [PAN_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_DEGREE) rule_deg = val[DEG_W-1:0];
    else rule_pans = val;
  endtask

  // the edge after the last pop lets valid rise before the idle check
  task automatic drain();
    wait (bound_q.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i && integral_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic push_pair(int a, int b);
    nci_in_t w;
    w.lower_bound = BOUND_W'(a);
    w.upper_bound = BOUND_W'(b);
    bound_q.push_back(w);
  endtask

  // mostly ordered random intervals, some reversed or empty
  task automatic push_random(int cnt, bit narrow);
    int a, b, t;
    for (int i = 0; i < cnt; i++) begin
      a = $signed(24'($urandom));
      b = $signed(24'($urandom));
      if (narrow) b = a + $urandom_range(0, 1 << 18);
      if (b > 8388607) b = 8388607;
      case ($urandom_range(0, 9))
        0: b = a;
        1: if (a < b) begin t = a; a = b; b = t; end
        default: if (a > b) begin t = a; a = b; b = t; end
      endcase
      push_pair(a, b);
    end
  endtask

  initial begin
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: trapezoid, single panel
    push_pair(0, 65536);
    push_pair(-8388608, 8388607);
    push_pair(8388607, -8388608);
    push_pair(12345, 12345);
    push_pair(-65536, 65536);
    push_pair(-8388608, -8388607);
    push_pair(8388606, 8388607);
    push_pair(-131072, -65536);
    drain();

    // degree above max clamps to 9
    write_reg(CFG_DEGREE, 9'h1FF);
    write_reg(CFG_PANELS, 9'd2);
    push_pair(-8388608, 8388607);
    push_pair(-65536, 196608);
    push_pair(0, 0);
    drain();

    // zero register values act as one
    write_reg(CFG_DEGREE, 9'd0);
    write_reg(CFG_PANELS, 9'd0);
    push_pair(-8388608, 8388607);
    push_pair(1, 2);
    drain();

    write_reg(CFG_DEGREE, 9'd1);
    write_reg(CFG_PANELS, 9'h1FF);
    push_pair(-8388608, 8388607);
    push_pair(-3, 5);
    drain();

    // largest rule, most panels
    write_reg(CFG_DEGREE, 9'd9);
    write_reg(CFG_PANELS, 9'd256);
    push_pair(-8388608, 8388607);
    drain();

    // negative weights of degree 8
    write_reg(CFG_DEGREE, 9'd8);
    write_reg(CFG_PANELS, 9'd3);
    push_pair(-8388608, 8388607);
    push_pair(-300000, -200000);
    drain();

    // long receiver hold while the sender keeps offering
    write_reg(CFG_DEGREE, 9'd2);
    write_reg(CFG_PANELS, 9'd1);
    hold_reqs = 1;
    push_random(6, 1'b0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      write_reg(CFG_DEGREE, 9'($urandom_range(1, 9)));
      write_reg(CFG_PANELS, 9'($urandom_range(1, 6)));
      if (ph == 8) no_idle = 1'b1;
      push_random(10, ph[0]);
      drain();
    end

    repeat (200) @(posedge clk_i);
    $display("ran %0d intervals through %0d results over rule degrees 0 to 9 and 15",
             words_in, words_out);
    $display("panel counts 0 to 6, 256 and 511, reversed and empty intervals, full-range bounds");
    if (error_cnt == 0) begin
      $display("newton_cotes_integrator_top: match");
    end else begin
      $display("newton_cotes_integrator_top: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", integral_q.size());
    $display("newton_cotes_integrator_top: mismatch");
    $finish;
  end

endmodule
